>>> src/nlet_pkg.sv
// Package for the netascii line ending translator.
// Holds the byte codes, register indexes, direction codes, config type and the run type shared by all modules.
// Depends on nothing.
package nlet_pkg;

   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_NUL = 8'h00;

   localparam int RUN_MAX = 4;

   localparam logic CSR_DIRECTION    = 1'b0;
   localparam logic CSR_HOST_NEWLINE = 1'b1;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] bytes;
      logic [2:0]              count;
   } run_type;

   typedef struct packed {
      logic direction;
      logic host_newline_crlf;
   } cfg_type;

endpackage

>>> src/nlet_front.sv
// Front end of the translator: accepts input words and classifies each into a run.
// Holds the pending carriage return flag. Depends on nlet_pkg.
module nlet_front (
   input  logic             clock,
   input  logic             reset,
   input  nlet_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   input  logic             req_end_of_transfer,
   input  logic             queue_full,
   output logic             push,
   output nlet_pkg::run_type push_run
);

   logic pending_ff;
   logic pending_in;
   logic accept;

   function automatic nlet_pkg::run_type add(nlet_pkg::run_type r, logic [7:0] b);
      nlet_pkg::run_type o;
      o = r;
      o.bytes[r.count[1:0]] = b;
      o.count = r.count + 3'd1;
      return o;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      nlet_pkg::run_type r;
      logic              newp;
      r    = '0;
      newp = 1'b0;
      if (cfg.direction == nlet_pkg::DIR_ENCODE) begin
         if (pending_ff && cfg.host_newline_crlf && req_data_byte == nlet_pkg::BYTE_LF) begin
            r = add(r, nlet_pkg::BYTE_CR);
            r = add(r, nlet_pkg::BYTE_LF);
         end else begin
            if (pending_ff) begin
               r = add(r, nlet_pkg::BYTE_CR);
               r = add(r, nlet_pkg::BYTE_NUL);
            end
            if (cfg.host_newline_crlf) begin
               if (req_data_byte == nlet_pkg::BYTE_CR) begin
                  newp = 1'b1;
               end else begin
                  r = add(r, req_data_byte);
               end
            end else if (req_data_byte == nlet_pkg::BYTE_LF) begin
               r = add(r, nlet_pkg::BYTE_CR);
               r = add(r, nlet_pkg::BYTE_LF);
            end else if (req_data_byte == nlet_pkg::BYTE_CR) begin
               r = add(r, nlet_pkg::BYTE_CR);
               r = add(r, nlet_pkg::BYTE_NUL);
            end else begin
               r = add(r, req_data_byte);
            end
         end
      end else begin
         if (pending_ff && req_data_byte == nlet_pkg::BYTE_LF) begin
            if (cfg.host_newline_crlf) begin
               r = add(r, nlet_pkg::BYTE_CR);
            end
            r = add(r, nlet_pkg::BYTE_LF);
         end else if (pending_ff && req_data_byte == nlet_pkg::BYTE_NUL) begin
            r = add(r, nlet_pkg::BYTE_CR);
         end else begin
            if (pending_ff) begin
               r = add(r, nlet_pkg::BYTE_CR);
            end
            if (req_data_byte == nlet_pkg::BYTE_CR) begin
               newp = 1'b1;
            end else begin
               r = add(r, req_data_byte);
            end
         end
      end
      if (req_end_of_transfer && newp) begin
         newp = 1'b0;
         r = add(r, nlet_pkg::BYTE_CR);
         if (cfg.direction == nlet_pkg::DIR_ENCODE) begin
            r = add(r, nlet_pkg::BYTE_NUL);
         end
      end
      push_run   = r;
      push       = accept && (r.count != 3'd0);
      pending_in = accept ? newp : pending_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

endmodule

>>> src/nlet_queue.sv
// Short queue of runs between the front and back ends.
// Depends on nlet_pkg.
module nlet_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nlet_pkg::run_type push_run,
   input  logic              pop,
   output logic              head_valid,
   output nlet_pkg::run_type head_run,
   output logic              full,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   nlet_pkg::run_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign head_run   = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == CW'(DEPTH));
   assign level      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

>>> src/nlet_back.sv
// Back end of the translator: unpacks runs into single output words.
// Drives the output register. Depends on nlet_pkg.
module nlet_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  nlet_pkg::run_type head_run,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_of_run
);

   nlet_pkg::run_type run_ff, run_in;
   logic [1:0] idx_ff, idx_in;
   logic       act_ff, act_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       advance;

   assign advance = !valid_ff || rsp_ready;

   always_comb begin
      pop      = 1'b0;
      run_in   = run_ff;
      idx_in   = idx_ff;
      act_in   = act_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      valid_in = advance ? 1'b0 : valid_ff;
      if (advance) begin
         if (act_ff) begin
            valid_in = 1'b1;
            byte_in  = run_ff.bytes[idx_ff];
            last_in  = ({1'b0, idx_ff} == run_ff.count - 3'd1);
            idx_in   = idx_ff + 2'd1;
            if (last_in) begin
               act_in = 1'b0;
            end
         end else if (head_valid) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            byte_in  = head_run.bytes[0];
            last_in  = (head_run.count == 3'd1);
            if (!last_in) begin
               act_in = 1'b1;
               run_in = head_run;
               idx_in = 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         act_ff   <= act_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff  <= run_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

>>> src/netascii_line_ending_translator_top.sv
// Top level of the netascii line ending translator.
// Instantiates nlet_front, nlet_queue and nlet_back; depends on nlet_pkg.
//
//   Channel  Direction  Handshake          Contents
//   req_     in         valid / ready      data_byte, end_of_transfer
//   rsp_     out        valid / ready      out_byte, last_of_run
//   csr_     in         write enable only  direction, host_newline_crlf
//
// Each input word is classified combinationally into a run of zero to four bytes.
// The back end issues one output word per cycle while rsp_ready is high and runs are queued.
// Input words are taken every cycle while the run queue has room.
// Reset clears the configuration, the held carriage return, the queue and the output valid flag.
// A stalled output fills the queue, after which req_ready falls.
module netascii_line_ending_translator_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_transfer,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   nlet_pkg::cfg_type cfg_ff, cfg_in;
   nlet_pkg::run_type push_run, head_run;
   logic push, pop, head_valid, queue_full;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_level;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            nlet_pkg::CSR_DIRECTION:    cfg_in.direction         = csr_write_data;
            nlet_pkg::CSR_HOST_NEWLINE: cfg_in.host_newline_crlf = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nlet_front u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_end_of_transfer (req_end_of_transfer),
      .queue_full          (queue_full),
      .push                (push),
      .push_run            (push_run)
   );

   nlet_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_run   (push_run),
      .pop        (pop),
      .head_valid (head_valid),
      .head_run   (head_run),
      .full       (queue_full),
      .level      (queue_level)
   );

   nlet_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_run        (head_run),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // The queue never holds more runs than it has room for.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      queue_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("run queue overfilled");

   // A run is only pushed while the queue has room.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("push into full run queue");

   // Every queued run holds between one and four bytes.
   a_run_size: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head_run.count != 3'd0 && head_run.count <= 3'd4))
      else $error("queued run has bad length");

endmodule
